// ===== src/dmf_pkg.sv =====
// Shared constants and types for the duplicate message filter.
`default_nettype none
package dmf_pkg;
	localparam int unsigned MAX_ENTRIES = 16;
	localparam int unsigned IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned KEY_W       = 32;
	localparam int unsigned TIME_W      = 32;
	localparam int unsigned IN_W        = KEY_W + TIME_W;
	localparam int unsigned OUT_W       = 8;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             key_we;
		logic             time_we;
		logic [IDX_W-1:0] wr_addr;
	} tab_req_t;

	typedef struct packed {
		logic table_full;
		logic was_inserted;
		logic is_duplicate;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_UPDATE = 3'b100
	} state_t;
endpackage
`default_nettype wire

// ===== src/duplicate_message_filter_unit.sv =====
// Top level of the duplicate message filter: stream ports, window register, result register.
// One item at a time: an accepted item walks the key table, one entry per cycle through
// the synchronous key/time RAM read port, stopping at the first match. The search reads at
// most the current fill (up to 16 entries); then the update state offers the result, the
// result register loads once it is free, and the next item is taken back in the idle state.
// With an empty table the search is skipped: the update state follows in the cycle after acceptance.
// The result sits in an output register, so the next item is taken while it waits; a second
// result that finds that register still occupied holds the search logic and the input.
// No clearing pass after reset: only entries below the fill count are read.
`default_nettype none
module duplicate_message_filter_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// sensor_id, sensor_type, value_type, key_byte, now_ticks
	input  wire logic [dmf_pkg::IN_W-1:0]      s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// is_duplicate, was_inserted, table_full, zero padding
	output logic      [dmf_pkg::OUT_W-1:0]     m_tdata,
	input  wire logic                          cfg_we,
	input  wire logic [dmf_pkg::TIME_W-1:0]    cfg_wdata
);
	logic [dmf_pkg::TIME_W-1:0] window_q;
	dmf_pkg::tab_req_t          req;
	logic [dmf_pkg::KEY_W-1:0]  key_wdata;
	logic [dmf_pkg::TIME_W-1:0] time_wdata;
	logic [dmf_pkg::KEY_W-1:0]  key_rdata;
	logic [dmf_pkg::TIME_W-1:0] time_rdata;
	logic                       res_valid;
	logic                       res_ready;
	dmf_pkg::result_t           res;
	logic                       out_valid_q;
	dmf_pkg::result_t           out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	dmf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_key     (s_tdata[dmf_pkg::KEY_W-1:0]),
		.in_now     (s_tdata[dmf_pkg::IN_W-1:dmf_pkg::KEY_W]),
		.window     (window_q),
		.req        (req),
		.key_wdata  (key_wdata),
		.time_wdata (time_wdata),
		.key_rdata  (key_rdata),
		.time_rdata (time_rdata),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	dmf_ram #(
		.WIDTH (dmf_pkg::KEY_W),
		.DEPTH (dmf_pkg::MAX_ENTRIES)
	) u_key_ram (
		.clk   (clk),
		.we    (req.key_we),
		.waddr (req.wr_addr),
		.wdata (key_wdata),
		.re    (req.rd_en),
		.raddr (req.rd_addr),
		.rdata (key_rdata)
	);

	dmf_ram #(
		.WIDTH (dmf_pkg::TIME_W),
		.DEPTH (dmf_pkg::MAX_ENTRIES)
	) u_time_ram (
		.clk   (clk),
		.we    (req.time_we),
		.waddr (req.wr_addr),
		.wdata (time_wdata),
		.re    (req.rd_en),
		.raddr (req.rd_addr),
		.rdata (time_rdata)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(dmf_pkg::OUT_W - 3){1'b0}}, out_res_q.table_full,
		out_res_q.was_inserted, out_res_q.is_duplicate};
endmodule
`default_nettype wire

// ===== src/dmf_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module dmf_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== src/dmf_ctrl.sv =====
// Search and update sequencer for the key and time tables.
`default_nettype none
module dmf_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [dmf_pkg::KEY_W-1:0]   in_key,
	input  wire logic [dmf_pkg::TIME_W-1:0]  in_now,
	input  wire logic [dmf_pkg::TIME_W-1:0]  window,
	output dmf_pkg::tab_req_t                req,
	output logic      [dmf_pkg::KEY_W-1:0]   key_wdata,
	output logic      [dmf_pkg::TIME_W-1:0]  time_wdata,
	input  wire logic [dmf_pkg::KEY_W-1:0]   key_rdata,
	input  wire logic [dmf_pkg::TIME_W-1:0]  time_rdata,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output dmf_pkg::result_t                 res
);
	dmf_pkg::state_t                 st_q;
	logic [dmf_pkg::CNT_W-1:0]       count_q;
	logic [dmf_pkg::CNT_W-1:0]       rd_idx_q;
	logic [dmf_pkg::CNT_W-1:0]       idx_s1;
	logic                            pend_s1;
	logic                            found_q;
	logic [dmf_pkg::IDX_W-1:0]       hit_q;
	logic [dmf_pkg::KEY_W-1:0]       key_q;
	logic [dmf_pkg::TIME_W-1:0]      now_q;
	logic [dmf_pkg::TIME_W-1:0]      last_q;
	logic [dmf_pkg::TIME_W-1:0]      elapsed;
	logic                            rd_go;
	logic                            match;
	logic                            last_idx;
	logic                            has_room;
	logic                            done;

	assign in_ready  = (st_q == dmf_pkg::ST_IDLE);
	assign rd_go     = (st_q == dmf_pkg::ST_SEARCH) && (rd_idx_q < count_q);
	assign match     = pend_s1 && (key_rdata == key_q);
	assign last_idx  = (dmf_pkg::CNT_W'(idx_s1 + dmf_pkg::CNT_W'(1)) == count_q);
	assign has_room  = (count_q < dmf_pkg::CNT_W'(dmf_pkg::MAX_ENTRIES));
	assign elapsed   = now_q - last_q;
	assign res_valid = (st_q == dmf_pkg::ST_UPDATE);
	assign done      = res_valid && res_ready;

	always_comb begin
		res.is_duplicate = found_q && (elapsed < window);
		res.was_inserted = !found_q && has_room;
		res.table_full   = !found_q && !has_room;
		req.rd_en        = rd_go;
		req.rd_addr      = rd_idx_q[dmf_pkg::IDX_W-1:0];
		req.key_we       = done && res.was_inserted;
		req.time_we      = done && (found_q || has_room);
		req.wr_addr      = found_q ? hit_q : count_q[dmf_pkg::IDX_W-1:0];
		key_wdata        = key_q;
		time_wdata       = now_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= dmf_pkg::ST_IDLE;
			count_q  <= '0;
			rd_idx_q <= '0;
			pend_s1  <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			unique case (st_q)
				dmf_pkg::ST_IDLE: begin
					if (in_valid) begin
						rd_idx_q <= '0;
						pend_s1  <= 1'b0;
						found_q  <= 1'b0;
						st_q     <= (count_q == '0) ? dmf_pkg::ST_UPDATE : dmf_pkg::ST_SEARCH;
					end
				end
				dmf_pkg::ST_SEARCH: begin
					if (rd_go) begin
						rd_idx_q <= dmf_pkg::CNT_W'(rd_idx_q + dmf_pkg::CNT_W'(1));
					end
					pend_s1 <= rd_go;
					if (match) begin
						found_q <= 1'b1;
						pend_s1 <= 1'b0;
						st_q    <= dmf_pkg::ST_UPDATE;
					end else if (pend_s1 && last_idx) begin
						pend_s1 <= 1'b0;
						st_q    <= dmf_pkg::ST_UPDATE;
					end
				end
				dmf_pkg::ST_UPDATE: begin
					if (done) begin
						if (res.was_inserted) begin
							count_q <= dmf_pkg::CNT_W'(count_q + dmf_pkg::CNT_W'(1));
						end
						st_q <= dmf_pkg::ST_IDLE;
					end
				end
				default: begin
					st_q <= dmf_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			key_q <= in_key;
			now_q <= in_now;
		end
		if (rd_go) begin
			idx_s1 <= rd_idx_q;
		end
		if (match) begin
			hit_q  <= idx_s1[dmf_pkg::IDX_W-1:0];
			last_q <= time_rdata;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dmf_pkg::CNT_W'(dmf_pkg::MAX_ENTRIES))
		else $error("entry count above table size");

	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $onehot0({res.is_duplicate, res.was_inserted, res.table_full}))
		else $error("more than one result flag set");

	a_count_only_on_insert: assert property (@(posedge clk) disable iff (!arst_n)
		!(done && res.was_inserted) |=> $stable(count_q))
		else $error("entry count changed without an insertion");

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("new item taken while one is in flight");
endmodule
`default_nettype wire
